// ----- rtl/chc_pkg.sv -----
package chc_pkg;

    localparam int INDEX_BITS    = 14;
    localparam int FIELD_IDX_W   = 14;
    localparam int ADDR_BITS     = INDEX_BITS + 1;
    localparam int DEPTH         = 1 << ADDR_BITS;
    localparam int ENTRY_W       = 16;
    localparam int ENTRY_MAX     = (1 << (ENTRY_W - 1)) - 1;
    localparam int ENTRY_MIN     = -(1 << (ENTRY_W - 1));
    localparam int GRAVITY_SHIFT = 10;
    localparam int GRAVITY_SCALE = 1 << GRAVITY_SHIFT;
    localparam int D_LIM         = GRAVITY_SCALE / 4;
    localparam int D_W           = 16;
    localparam int OPND_W        = 16;
    localparam int PROD_W        = ENTRY_W + OPND_W + 1;
    localparam int GRAV_W        = PROD_W + 1;
    localparam int NUM_LANES     = 5;
    localparam int SUM_W         = PROD_W + 3;
    localparam int CORR_SHIFT    = 11;
    localparam int CORR_DIVISOR  = 1 << CORR_SHIFT;
    localparam int VALUE_W       = 32;
    localparam int TOTAL_W       = SUM_W + 2;
    localparam int WEIGHT_W      = 10;
    localparam int LIMIT_W       = 16;
    localparam int OUT_W         = 17;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_ADJUST = 1'b1;

    localparam logic [WEIGHT_W-1:0] RST_W_PAWN     = WEIGHT_W'(200);
    localparam logic [WEIGHT_W-1:0] RST_W_NON_PAWN = WEIGHT_W'(160);
    localparam logic [WEIGHT_W-1:0] RST_W_MINOR    = WEIGHT_W'(150);
    localparam logic [WEIGHT_W-1:0] RST_W_MAJOR    = WEIGHT_W'(140);
    localparam logic [WEIGHT_W-1:0] RST_W_THREAT   = WEIGHT_W'(150);
    localparam logic [LIMIT_W-1:0]  RST_LIMIT      = LIMIT_W'(40000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_W_PAWN     = 3'd0,
        REG_W_NON_PAWN = 3'd1,
        REG_W_MINOR    = 3'd2,
        REG_W_MAJOR    = 3'd3,
        REG_W_THREAT   = 3'd4,
        REG_LIMIT      = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic                   clear;
        logic [ADDR_BITS-1:0]   clear_addr;
        logic                   mul_en;
        logic                   write_en;
        logic                   op;
        logic signed [D_W-1:0]  d;
    } lane_ctrl_t;

    typedef struct packed {
        logic sum_en;
        logic total_en;
        logic out_en;
    } merge_ctrl_t;

    function automatic logic [ADDR_BITS-1:0] make_addr(input logic side,
                                                       input logic [FIELD_IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return {side, wide[INDEX_BITS-1:0]};
    endfunction

endpackage

// ----- rtl/chc_ram.sv -----
module chc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/chc_lane.sv -----
module chc_lane
    import chc_pkg::*;
(
    input  logic                        aclk,
    input  lane_ctrl_t                  ctrl,
    input  logic [ADDR_BITS-1:0]        addr,
    input  logic [WEIGHT_W-1:0]         weight,
    output logic signed [PROD_W-1:0]    prod
);

    logic [ENTRY_W-1:0]         rdata;
    logic [ENTRY_W-1:0]         wdata;
    logic [ADDR_BITS-1:0]       ram_addr;
    logic                       ram_we;
    logic signed [ENTRY_W-1:0]  h_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic [OPND_W-1:0]          ad;
    logic [OPND_W-1:0]          opnd;
    logic signed [PROD_W-1:0]   round_add;
    logic signed [PROD_W-1:0]   quot;
    logic signed [GRAV_W-1:0]   n_full;
    logic signed [ENTRY_W-1:0]  n_sat;

    chc_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(wdata),
        .rdata(rdata)
    );

    assign ram_addr = ctrl.clear ? ctrl.clear_addr : addr;
    assign ram_we   = ctrl.clear | ctrl.write_en;
    assign wdata    = ctrl.clear ? '0 : n_sat;

    // one multiplier serves both the gravity term and the weighted entry
    always_comb begin
        ad        = ctrl.d[D_W-1] ? OPND_W'(-ctrl.d) : OPND_W'(ctrl.d);
        opnd      = (ctrl.op == OP_ADJUST) ? OPND_W'(weight) : ad;
        prod_next = PROD_W'($signed(rdata)) * $signed({1'b0, opnd});
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            h_reg    <= $signed(rdata);
            prod_reg <= prod_next;
        end
    end

    // truncate toward zero, then saturate to the entry range
    always_comb begin
        round_add = prod_reg[PROD_W-1] ? PROD_W'(GRAVITY_SCALE - 1) : '0;
        quot      = (prod_reg + round_add) >>> GRAVITY_SHIFT;
        n_full    = GRAV_W'(h_reg) + GRAV_W'(ctrl.d) - GRAV_W'(quot);
        if (n_full > $signed(GRAV_W'(ENTRY_MAX))) begin
            n_sat = ENTRY_W'(ENTRY_MAX);
        end else if (n_full < $signed(GRAV_W'(ENTRY_MIN))) begin
            n_sat = ENTRY_W'(ENTRY_MIN);
        end else begin
            n_sat = n_full[ENTRY_W-1:0];
        end
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/chc_merge.sv -----
module chc_merge
    import chc_pkg::*;
(
    input  logic                        aclk,
    input  merge_ctrl_t                 ctrl,
    input  logic signed [PROD_W-1:0]    prod [NUM_LANES],
    input  logic signed [VALUE_W-1:0]   value,
    input  logic [LIMIT_W-1:0]          limit,
    output logic signed [OUT_W-1:0]     adjusted_eval
);

    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [SUM_W-1:0]   round_add;
    logic signed [SUM_W-1:0]   quot;
    logic signed [TOTAL_W-1:0] total_reg;
    logic signed [TOTAL_W-1:0] total_next;
    logic signed [TOTAL_W-1:0] lim;
    logic signed [OUT_W-1:0]   out_reg;
    logic signed [OUT_W-1:0]   out_next;

    always_comb begin
        sum_next = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            sum_next = sum_next + SUM_W'(prod[i]);
        end
    end

    always_comb begin
        round_add  = sum_reg[SUM_W-1] ? SUM_W'(CORR_DIVISOR - 1) : '0;
        quot       = (sum_reg + round_add) >>> CORR_SHIFT;
        total_next = TOTAL_W'(value) + TOTAL_W'(quot);
    end

    always_comb begin
        lim = $signed(TOTAL_W'(limit));
        if (total_reg > lim) begin
            out_next = OUT_W'(lim);
        end else if (total_reg < -lim) begin
            out_next = OUT_W'(-lim);
        end else begin
            out_next = total_reg[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.sum_en) begin
            sum_reg <= sum_next;
        end
        if (ctrl.total_en) begin
            total_reg <= total_next;
        end
        if (ctrl.out_en) begin
            out_reg <= out_next;
        end
    end

    assign adjusted_eval = out_reg;

endmodule

// ----- rtl/correction_history_tables.sv -----
// Update item: accepted, then read, multiply and write-back in turn; no new
// item is taken until the write-back is done.
// Adjust item: registered table read, lane multiply, then the merge sum,
// total and output registers; waits on a stalled output, then takes the next.
// Reset: weights and limit return to defaults; a clearing pass over all rows
// (one table row a cycle) zeroes all five tables, with s_ready low meanwhile.
module correction_history_tables
    import chc_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_op,
    input  logic                        s_side,
    input  logic [FIELD_IDX_W-1:0]      s_pawn_index,
    input  logic [FIELD_IDX_W-1:0]      s_non_pawn_index,
    input  logic [FIELD_IDX_W-1:0]      s_minor_index,
    input  logic [FIELD_IDX_W-1:0]      s_major_index,
    input  logic [FIELD_IDX_W-1:0]      s_threat_index,
    input  logic signed [VALUE_W-1:0]   s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [OUT_W-1:0]     m_adjusted_eval,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_READ  = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_FIN   = 7'b0010000,
        ST_SUM   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t                     state_reg, state_next;
    logic [ADDR_BITS-1:0]       clear_cnt_reg, clear_cnt_next;
    logic                       m_valid_reg, m_valid_next;
    logic                       op_reg;
    logic signed [D_W-1:0]      d_reg, d_next;
    logic signed [VALUE_W-1:0]  value_reg;
    logic [ADDR_BITS-1:0]       addr_reg [NUM_LANES];
    logic [WEIGHT_W-1:0]        weight_reg [NUM_LANES];
    logic [LIMIT_W-1:0]         limit_reg;
    logic signed [PROD_W-1:0]   prod [NUM_LANES];
    lane_ctrl_t                 lane_ctrl;
    merge_ctrl_t                merge_ctrl;
    logic                       accept;
    logic                       load_out;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid & s_ready;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg[0] <= RST_W_PAWN;
            weight_reg[1] <= RST_W_NON_PAWN;
            weight_reg[2] <= RST_W_MINOR;
            weight_reg[3] <= RST_W_MAJOR;
            weight_reg[4] <= RST_W_THREAT;
            limit_reg     <= RST_LIMIT;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_W_PAWN:     weight_reg[0] <= cfg_data[WEIGHT_W-1:0];
                REG_W_NON_PAWN: weight_reg[1] <= cfg_data[WEIGHT_W-1:0];
                REG_W_MINOR:    weight_reg[2] <= cfg_data[WEIGHT_W-1:0];
                REG_W_MAJOR:    weight_reg[3] <= cfg_data[WEIGHT_W-1:0];
                REG_W_THREAT:   weight_reg[4] <= cfg_data[WEIGHT_W-1:0];
                REG_LIMIT:      limit_reg     <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp the difference once, at acceptance
    always_comb begin
        if (s_value > $signed(VALUE_W'(D_LIM))) begin
            d_next = D_W'(D_LIM);
        end else if (s_value < $signed(-VALUE_W'(D_LIM))) begin
            d_next = -D_W'(D_LIM);
        end else begin
            d_next = s_value[D_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg      <= s_op;
            d_reg       <= d_next;
            value_reg   <= s_value;
            addr_reg[0] <= make_addr(s_side, s_pawn_index);
            addr_reg[1] <= make_addr(s_side, s_non_pawn_index);
            addr_reg[2] <= make_addr(s_side, s_minor_index);
            addr_reg[3] <= make_addr(s_side, s_major_index);
            addr_reg[4] <= make_addr(s_side, s_threat_index);
        end
    end

    always_comb begin
        state_next     = state_reg;
        clear_cnt_next = clear_cnt_reg;
        load_out       = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                clear_cnt_next = clear_cnt_reg + 1'b1;
                if (clear_cnt_reg == ADDR_BITS'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:  if (accept) state_next = ST_READ;
            ST_READ:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_FIN;
            ST_FIN:   state_next = (op_reg == OP_ADJUST) ? ST_SUM : ST_IDLE;
            ST_SUM:   state_next = ST_OUT;
            ST_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_CLEAR;
        endcase
        m_valid_next = (m_valid_reg & ~m_ready) | load_out;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clear_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_comb begin
        lane_ctrl.clear      = (state_reg == ST_CLEAR);
        lane_ctrl.clear_addr = clear_cnt_reg;
        lane_ctrl.mul_en     = (state_reg == ST_MUL);
        lane_ctrl.write_en   = (state_reg == ST_FIN) && (op_reg == OP_UPDATE);
        lane_ctrl.op         = op_reg;
        lane_ctrl.d          = d_reg;
        merge_ctrl.sum_en    = (state_reg == ST_FIN);
        merge_ctrl.total_en  = (state_reg == ST_SUM);
        merge_ctrl.out_en    = load_out;
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        chc_lane u_lane (
            .aclk  (aclk),
            .ctrl  (lane_ctrl),
            .addr  (addr_reg[g]),
            .weight(weight_reg[g]),
            .prod  (prod[g])
        );
    end

    chc_merge u_merge (
        .aclk         (aclk),
        .ctrl         (merge_ctrl),
        .prod         (prod),
        .value        (value_reg),
        .limit        (limit_reg),
        .adjusted_eval(m_adjusted_eval)
    );

endmodule

// ----- rtl/chc_checker.sv -----
module chc_checker
    import chc_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic                        s_op,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic signed [OUT_W-1:0]     m_adjusted_eval
);

    // held result must not change before it is taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_adjusted_eval))
        else $error("result changed while stalled");

    // one item in flight: ready drops after every acceptance
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while busy");

    // an update item never raises a result
    a_update_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op == OP_UPDATE) |=> !$rose(m_valid))
        else $error("result after update item");

    // reset drops both handshakes and starts the clearing pass
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("handshake active after reset");

endmodule

bind correction_history_tables chc_checker u_chc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_op           (s_op),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_adjusted_eval(m_adjusted_eval)
);

// ----- dv/chc_checker.sv -----
`timescale 1ns / 100ps

module chc_scoreboard
    import chc_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic                        s_op,
    input  logic                        s_side,
    input  logic [FIELD_IDX_W-1:0]      s_pawn_index,
    input  logic [FIELD_IDX_W-1:0]      s_non_pawn_index,
    input  logic [FIELD_IDX_W-1:0]      s_minor_index,
    input  logic [FIELD_IDX_W-1:0]      s_major_index,
    input  logic [FIELD_IDX_W-1:0]      s_threat_index,
    input  logic signed [VALUE_W-1:0]   s_value,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic signed [OUT_W-1:0]     m_adjusted_eval,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    output int                          mismatches,
    output int                          in_flight,
    output int                          checked
);

    // Lanes in register order: pawn, non-pawn, minor, major, threat.
    logic signed [ENTRY_W-1:0]  history [NUM_LANES][DEPTH];
    logic [WEIGHT_W-1:0]        weight [NUM_LANES];
    logic [LIMIT_W-1:0]         limit;
    logic [FIELD_IDX_W-1:0]     keys [NUM_LANES];
    logic [ADDR_BITS-1:0]       lane_addr [NUM_LANES];
    logic signed [OUT_W-1:0]    expected_evals [$];

    function automatic logic [ADDR_BITS-1:0] entry_addr(input logic side,
                                                        input logic [FIELD_IDX_W-1:0] key);
        return {side, key[INDEX_BITS-1:0]};
    endfunction

    task automatic apply_gravity(input int lane, input longint d);
        longint h;
        longint mag;
        longint n;
        h   = history[lane][lane_addr[lane]];
        mag = (d < 0) ? -d : d;
        n   = h + d - (h * mag) / GRAVITY_SCALE;
        if (n > ENTRY_MAX) n = ENTRY_MAX;
        if (n < ENTRY_MIN) n = ENTRY_MIN;
        history[lane][lane_addr[lane]] = ENTRY_W'(n);
    endtask

    function automatic logic signed [OUT_W-1:0] corrected_eval(input longint raw);
        longint sum;
        longint r;
        longint lim;
        sum = 0;
        for (int l = 0; l < NUM_LANES; l++)
            sum += longint'(weight[l]) * longint'(history[l][lane_addr[l]]);
        r   = raw + sum / CORR_DIVISOR;
        lim = longint'(limit);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return OUT_W'(r);
    endfunction

    always @(posedge aclk) begin
        longint v;
        longint d;
        logic signed [OUT_W-1:0] want;
        if (!aresetn) begin
            foreach (history[l, e]) history[l][e] = '0;
            weight[REG_W_PAWN]     = RST_W_PAWN;
            weight[REG_W_NON_PAWN] = RST_W_NON_PAWN;
            weight[REG_W_MINOR]    = RST_W_MINOR;
            weight[REG_W_MAJOR]    = RST_W_MAJOR;
            weight[REG_W_THREAT]   = RST_W_THREAT;
            limit = RST_LIMIT;
            expected_evals.delete();
            mismatches <= 0;
            in_flight  <= 0;
            checked    <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_W_PAWN, REG_W_NON_PAWN, REG_W_MINOR, REG_W_MAJOR, REG_W_THREAT:
                        weight[cfg_index] = cfg_data[WEIGHT_W-1:0];
                    REG_LIMIT: limit = cfg_data[LIMIT_W-1:0];
                    default: ;  // unmapped index: leave the settings alone
                endcase
            end

            // Retire results before taking the new item on the same edge.
            if (m_valid && m_ready) begin
                if (expected_evals.size() == 0) begin
                    $error("adjusted_eval: expected nothing, actual %0d", m_adjusted_eval);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_evals.pop_front();
                    checked <= checked + 1;
                    if (m_adjusted_eval !== want) begin
                        $error("adjusted_eval: expected %0d, actual %0d",
                               want, m_adjusted_eval);
                        mismatches <= mismatches + 1;
                    end
                end
            end

            if (s_valid && s_ready) begin
                keys[0] = s_pawn_index;
                keys[1] = s_non_pawn_index;
                keys[2] = s_minor_index;
                keys[3] = s_major_index;
                keys[4] = s_threat_index;
                for (int l = 0; l < NUM_LANES; l++)
                    lane_addr[l] = entry_addr(s_side, keys[l]);
                v = s_value;
                if (s_op == OP_UPDATE) begin
                    d = (v > D_LIM) ? D_LIM : ((v < -D_LIM) ? -D_LIM : v);
                    for (int l = 0; l < NUM_LANES; l++)
                        apply_gravity(l, d);
                end else begin
                    expected_evals.push_back(corrected_eval(v));
                end
            end

            in_flight <= expected_evals.size();
        end
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import chc_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 100000;
    localparam int HOT_KEYS      = 8;
    localparam int NUM_REGS      = REG_LIMIT + 1;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic                                   op;
        logic                                   side;
        logic [NUM_LANES-1:0][FIELD_IDX_W-1:0]  idx;
        logic signed [VALUE_W-1:0]              value;
    } lookup_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_op = OP_UPDATE;
    logic                       s_side = 1'b0;
    logic [FIELD_IDX_W-1:0]     s_pawn_index = '0;
    logic [FIELD_IDX_W-1:0]     s_non_pawn_index = '0;
    logic [FIELD_IDX_W-1:0]     s_minor_index = '0;
    logic [FIELD_IDX_W-1:0]     s_major_index = '0;
    logic [FIELD_IDX_W-1:0]     s_threat_index = '0;
    logic signed [VALUE_W-1:0]  s_value = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [OUT_W-1:0]    m_adjusted_eval;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = REG_W_PAWN;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;

    int mismatches;
    int in_flight;
    int checked;

    int  rx_idle_pct = 0;
    logic rx_hold_go = 1'b0;
    int  hold_left = 0;
    int  quiet = 0;
    int  n_updates = 0;
    int  n_adjusts = 0;

    logic [NUM_LANES-1:0][FIELD_IDX_W-1:0] hot_keys [HOT_KEYS];
    logic [CFG_DATA_W-1:0] next_regs [NUM_REGS];

    correction_history_tables u_dut (.*);
    chc_scoreboard u_checker (.*);

    always #HALF_PERIOD aclk = ~aclk;

    // Result side: random back-pressure, or a long hold when asked for.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (rx_hold_go) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", quiet);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic lookup_t same_keys(input logic op, input logic side,
                                          input logic [FIELD_IDX_W-1:0] key,
                                          input logic signed [VALUE_W-1:0] value);
        lookup_t lk;
        lk.op    = op;
        lk.side  = side;
        lk.idx   = {NUM_LANES{key}};
        lk.value = value;
        return lk;
    endfunction

    // Mostly revisit a few hot positions so the entries build up.
    function automatic lookup_t random_lookup();
        lookup_t lk;
        int pick;
        lk.op   = ($urandom_range(99) < 55) ? OP_UPDATE : OP_ADJUST;
        lk.side = 1'($urandom);
        if ($urandom_range(99) < 75) begin
            lk.idx = hot_keys[$urandom_range(0, HOT_KEYS - 1)];
        end else begin
            for (int l = 0; l < NUM_LANES; l++) lk.idx[l] = FIELD_IDX_W'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 20)
            lk.value = $urandom;
        else if (lk.op == OP_UPDATE)
            lk.value = (pick < 40) ? ((pick % 2) ? D_LIM : -D_LIM)
                                   : int'($urandom_range(0, 600)) - 300;
        else
            lk.value = (pick < 40) ? int'($urandom_range(0, 140000)) - 70000
                                   : int'($urandom_range(0, 10000)) - 5000;
        return lk;
    endfunction

    task automatic offer(input lookup_t lk);
        s_valid          <= 1'b1;
        s_op             <= lk.op;
        s_side           <= lk.side;
        s_pawn_index     <= lk.idx[0];
        s_non_pawn_index <= lk.idx[1];
        s_minor_index    <= lk.idx[2];
        s_major_index    <= lk.idx[3];
        s_threat_index   <= lk.idx[4];
        s_value          <= lk.value;
        do @(posedge aclk); while (!s_ready);
        if (lk.op == OP_UPDATE) n_updates++;
        else n_adjusts++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (in_flight != 0) @(posedge aclk);
        // updates give no result, so let the last one finish
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_settings();
        for (int r = 0; r < NUM_REGS; r++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(r);
            cfg_data  <= next_regs[r];
            @(posedge aclk);
        end
        cfg_index <= CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI));
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_items(input int count, input int tx_idle, input int pause_at);
        for (int i = 0; i < count; i++) begin
            if (i == pause_at) wait_drained();
            while ($urandom_range(99) < tx_idle) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
            offer(random_lookup());
        end
    endtask

    initial begin
        lookup_t mixed;
        hot_keys[0] = '0;
        hot_keys[1] = '1;
        for (int k = 2; k < HOT_KEYS; k++)
            for (int l = 0; l < NUM_LANES; l++) hot_keys[k][l] = FIELD_IDX_W'($urandom);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, reset settings.
        offer(same_keys(OP_ADJUST, 1'b0, '0, 0));
        offer(same_keys(OP_ADJUST, 1'b1, '1, 32'sh7FFF_FFFF));
        offer(same_keys(OP_ADJUST, 1'b1, '1, 32'sh8000_0000));
        offer(same_keys(OP_UPDATE, 1'b0, '0, 32'sh7FFF_FFFF));
        offer(same_keys(OP_UPDATE, 1'b0, '0, 32'sh7FFF_FFFF));
        offer(same_keys(OP_ADJUST, 1'b0, '0, 0));
        offer(same_keys(OP_ADJUST, 1'b1, '0, 0));
        offer(same_keys(OP_UPDATE, 1'b1, '1, 32'sh8000_0000));
        offer(same_keys(OP_UPDATE, 1'b1, '1, -1));
        offer(same_keys(OP_UPDATE, 1'b1, '1, 300));
        offer(same_keys(OP_ADJUST, 1'b1, '1, -12345));
        offer(same_keys(OP_UPDATE, 1'b0, '0, 0));
        offer(same_keys(OP_UPDATE, 1'b0, '0, 255));
        offer(same_keys(OP_UPDATE, 1'b0, '0, -257));
        offer(same_keys(OP_ADJUST, 1'b0, '0, 39000));
        mixed.op    = OP_UPDATE;
        mixed.side  = 1'b1;
        mixed.idx   = {14'h1FFF, 14'h1555, 14'h2AAA, 14'h0000, 14'h3FFF};
        mixed.value = D_LIM;
        offer(mixed);
        mixed.op    = OP_ADJUST;
        mixed.value = -40000;
        offer(mixed);
        repeat (3) offer(same_keys(OP_UPDATE, 1'b0, 14'd5, D_LIM));
        offer(same_keys(OP_ADJUST, 1'b0, 14'd5, 40000));
        offer(same_keys(OP_ADJUST, 1'b1, 14'd5, 0));
        wait_drained();

        // Widest settings; slow receiver.
        foreach (next_regs[r]) next_regs[r] = '1;
        load_settings();
        rx_idle_pct <= 84;
        run_items(350, 22, -1);
        wait_drained();

        // Everything zero; slow sender.
        foreach (next_regs[r]) next_regs[r] = '0;
        load_settings();
        rx_idle_pct <= 22;
        run_items(60, 84, -1);
        wait_drained();

        foreach (next_regs[r]) next_regs[r] = CFG_DATA_W'($urandom);
        load_settings();
        run_items(350, 84, -1);
        wait_drained();

        // Tight clamp, no idling; stall the output long enough to back up the input.
        foreach (next_regs[r]) next_regs[r] = CFG_DATA_W'($urandom);
        next_regs[REG_LIMIT] = CFG_DATA_W'($urandom_range(0, 400));
        load_settings();
        rx_idle_pct <= 0;
        rx_hold_go  <= 1'b1;
        @(posedge aclk);
        rx_hold_go  <= 1'b0;
        run_items(420, 0, 210);
        wait_drained();

        $display("summary: %0d update and %0d adjust items over five register settings",
                 n_updates, n_adjusts);
        $display("summary: %0d corrected evaluations compared, %0d mismatches",
                 checked, mismatches);
        if (mismatches == 0 && in_flight == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
